// ===== design/ulf_pkg.sv =====
// Shared constants, base-letter table and helper functions for the UTF-8 Latin fold stream.
`default_nettype none

package ulf_pkg;

  // Byte classes and masks
  localparam logic [7:0] LeadMask     = 8'hE0;
  localparam logic [7:0] LeadTag      = 8'hC0;
  localparam logic [1:0] ContTag      = 2'b10;
  localparam logic [2:0] LeadPrefix   = 3'b110;

  // Code point window covered by the base-letter table
  localparam logic [10:0] CpLow       = 11'h0C0;
  localparam logic [10:0] CpHigh      = 11'h180;
  localparam int          TableDepth  = 192;

  // Table codes: lower-case letter maps to itself, others are special
  localparam logic [7:0] CodeUnmapped = 8'h2E; // '.'
  localparam logic [7:0] CodeSharpS   = 8'h53; // 'S' -> "ss"
  localparam logic [7:0] CodeAe       = 8'h41; // 'A' -> "ae"
  localparam logic [7:0] CodeOe       = 8'h4F; // 'O' -> "oe"
  localparam logic [7:0] CodeThorn    = 8'h54; // 'T' -> "th"

  localparam logic [15:0] PairSs = "ss";
  localparam logic [15:0] PairAe = "ae";
  localparam logic [15:0] PairOe = "oe";
  localparam logic [15:0] PairTh = "th";

  localparam logic [7:0] CaseOffset = 8'd32;

  // Entry 0 (U+00C0) sits in the top byte
  localparam logic [8*TableDepth-1:0] BaseTable = {
    "aaaaaaAceeeeiiii",
    "dnooooo.ouuuuyTS",
    "aaaaaaAceeeeiiii",
    "dnooooo.ouuuuyTy",
    "aaaaaaccccccccdd",
    "ddeeeeeeeeeegggg",
    "gggghhhhiiiiiiii",
    "ii..jjkkklllllll",
    "lllnnnnnnn..oooo",
    "ooOOrrrrrrssssss",
    "ssttttttuuuuuuuu",
    "uuuuwwyyyzzzzzz."
  };

  function automatic logic [7:0] base_code(input logic [7:0] idx);
    logic [7:0] rev;
    logic [7:0] code;
    rev  = 8'(TableDepth - 1) - idx;
    code = CodeUnmapped;
    if (idx < 8'(TableDepth)) begin
      code = BaseTable[{rev, 3'b000} +: 8];
    end
    return code;
  endfunction

  function automatic logic is_ligature(input logic [7:0] code);
    return (code == CodeSharpS) || (code == CodeAe) ||
           (code == CodeOe) || (code == CodeThorn);
  endfunction

  function automatic logic [15:0] ligature_pair(input logic [7:0] code);
    logic [15:0] pair;
    case (code)
      CodeSharpS: pair = PairSs;
      CodeAe:     pair = PairAe;
      CodeOe:     pair = PairOe;
      CodeThorn:  pair = PairTh;
      default:    pair = {8'h00, code};
    endcase
    return pair;
  endfunction

endpackage

`default_nettype wire

// ===== design/utf8_latin_fold_stream_unit.sv =====
// Top level of the UTF-8 Latin fold stream: byte-in, byte-out text folder.
`default_nettype none

// Folds a UTF-8 text one beat (byte) at a time for case- and accent-blind
// comparison. ASCII A..Z become a..z; a two-byte sequence whose code point
// lies in U+00C0..U+017F and has a base letter becomes that letter, or two
// letters for the ligatures ss, ae, oe and th. Anything else passes through
// unchanged, and a lead byte that cannot be paired is released before the
// byte that broke the pair. Both channels use valid/stall: a beat moves on a
// rising edge with valid high and stall low. An input beat is registered,
// then folded into a two-byte result slot once that slot is empty or gives
// up its last byte, and its bytes leave one per cycle from that slot while
// out_stall is low. Throughput is one input beat per cycle while each beat
// yields at most one byte and out_stall is low; a beat that yields two
// bytes holds back the next beat until its first byte has left, as the
// result port takes a single byte. out_run_last marks the last byte caused
// by one input beat; out_text_end marks the final byte of a text (a beat
// with in_text_last always yields a byte and leaves no lead byte held).

module utf8_latin_fold_stream_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_text_last,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_byte,
  output      logic       out_run_last,
  output      logic       out_text_end
);
  import ulf_pkg::*;

  // Input register
  logic       ir_valid_r, ir_valid_nxt;
  logic [7:0] ir_byte_r;
  logic       ir_last_r;

  // Held lead byte
  logic       lead_pending_r, lead_pending_nxt;
  logic [4:0] lead_bits_r, lead_bits_nxt;

  // Result slot: byte0 goes first when two bytes are queued, a single byte
  // always sits in byte1
  logic [7:0] res_byte0_r, res_byte1_r;
  logic [1:0] res_cnt_r, res_cnt_nxt;
  logic       res_last_r;

  logic       in_take;
  logic       drain;
  logic       fire;

  // Fold datapath
  logic [10:0] cp;
  logic [7:0]  idx;
  logic        is_cont;
  logic        in_window;
  logic [7:0]  code;
  logic        mapped;
  logic [15:0] lig;
  logic [7:0]  lead_byte;
  logic        own_n;
  logic [7:0]  own_byte;
  logic        own_pend;
  logic [1:0]  res_n;
  logic [7:0]  res_b0, res_b1;

  assign in_take   = in_valid && !in_stall;
  assign drain     = out_valid && !out_stall;
  // Fold a beat when the slot is empty or gives up its last byte now
  assign fire      = ir_valid_r && ((res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && drain));
  assign in_stall  = ir_valid_r && !fire;

  assign cp        = {lead_bits_r, ir_byte_r[5:0]};
  assign idx       = 8'(cp - CpLow);
  assign is_cont   = (ir_byte_r[7:6] == ContTag);
  assign in_window = (cp >= CpLow) && (cp < CpHigh);
  assign code      = base_code(idx);
  assign mapped    = lead_pending_r && is_cont && in_window && (code != CodeUnmapped);
  assign lig       = ligature_pair(code);
  assign lead_byte = {LeadPrefix, lead_bits_r};

  // The current byte taken on its own
  always_comb begin
    own_n    = 1'b1;
    own_byte = ir_byte_r;
    own_pend = 1'b0;
    if (!ir_byte_r[7]) begin
      if (ir_byte_r inside {["A":"Z"]}) begin
        own_byte = ir_byte_r + CaseOffset;
      end
    end else if (((ir_byte_r & LeadMask) == LeadTag) && !ir_last_r) begin
      own_n    = 1'b0;
      own_pend = 1'b1;
    end
  end

  always_comb begin
    res_n  = 2'd0;
    res_b0 = 8'h00;
    res_b1 = 8'h00;
    if (mapped) begin
      if (is_ligature(code)) begin
        res_n  = 2'd2;
        res_b0 = lig[15:8];
        res_b1 = lig[7:0];
      end else begin
        res_n  = 2'd1;
        res_b1 = code;
      end
    end else if (lead_pending_r) begin
      // Release the held lead byte ahead of the current byte
      if (own_n) begin
        res_n  = 2'd2;
        res_b0 = lead_byte;
        res_b1 = own_byte;
      end else begin
        res_n  = 2'd1;
        res_b1 = lead_byte;
      end
    end else begin
      res_n  = {1'b0, own_n};
      res_b1 = own_byte;
    end
  end

  always_comb begin
    lead_pending_nxt = lead_pending_r;
    lead_bits_nxt    = lead_bits_r;
    if (fire) begin
      lead_pending_nxt = !mapped && own_pend;
      lead_bits_nxt    = (!mapped && own_pend) ? ir_byte_r[4:0] : 5'd0;
    end
  end

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (in_take) begin
      ir_valid_nxt = 1'b1;
    end else if (fire) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (fire) begin
      res_cnt_nxt = res_n;
    end else if (drain) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r     <= 1'b0;
      lead_pending_r <= 1'b0;
      lead_bits_r    <= 5'd0;
      res_cnt_r      <= 2'd0;
    end else begin
      ir_valid_r     <= ir_valid_nxt;
      lead_pending_r <= lead_pending_nxt;
      lead_bits_r    <= lead_bits_nxt;
      res_cnt_r      <= res_cnt_nxt;
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_take) begin
      ir_byte_r <= in_byte;
      ir_last_r <= in_text_last;
    end
    if (fire) begin
      res_byte0_r <= res_b0;
      res_byte1_r <= res_b1;
      res_last_r  <= ir_last_r;
    end
  end

  assign out_valid    = (res_cnt_r != 2'd0);
  assign out_byte     = (res_cnt_r == 2'd2) ? res_byte0_r : res_byte1_r;
  assign out_run_last = (res_cnt_r == 2'd1);
  assign out_text_end = (res_cnt_r == 2'd1) && res_last_r;

  // A beat that ends the text always yields a byte
  a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ir_last_r |-> res_n != 2'd0)
    else $error("text end folded without a result byte");

  // Nothing is held across a text boundary
  a_last_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ir_last_r |=> !lead_pending_r)
    else $error("lead byte held after end of text");

  // A silent beat is always a lead byte being held
  a_silent_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_n == 2'd0 |=> lead_pending_r)
    else $error("beat dropped without holding a lead byte");

  // A two-byte result opens with a byte that is not the last of its run
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_n == 2'd2 |=> out_valid && !out_run_last)
    else $error("two-byte result lost its first byte");

endmodule

`default_nettype wire

// ===== verif/utf8_latin_fold_stream_unit_test.sv =====
// Self-checking testbench for the UTF-8 Latin fold stream unit.
`default_nettype none

module utf8_latin_fold_stream_unit_test;

  // Codes of the base-letter map: a lower-case letter stands for itself,
  // the capitals stand for the two-letter ligatures.
  localparam logic [7:0] NoBase  = 8'h2E;
  localparam logic [7:0] LigSs   = 8'h53;
  localparam logic [7:0] LigAe   = 8'h41;
  localparam logic [7:0] LigOe   = 8'h4F;
  localparam logic [7:0] LigTh   = 8'h54;
  localparam logic [7:0] CaseGap = 8'd32;

  // Byte classes of UTF-8
  localparam logic [2:0] LeadTag = 3'b110;
  localparam logic [1:0] ContTag = 2'b10;

  // Window of code points that the map covers
  localparam logic [10:0] WindowLow  = 11'h0C0;
  localparam logic [10:0] WindowHigh = 11'h180;
  localparam int          MapDepth   = 192;

  localparam int LongHoldCycles = 400;
  localparam int WatchdogLimit  = 2000;
  localparam int SettleCycles   = 16;

  // Base letter per code point from U+00C0 upwards; the first entry sits in
  // the top byte.
  localparam logic [8*MapDepth-1:0] AccentBase = {
    "aaaaaaAceeeeiiii", "dnooooo.ouuuuyTS",
    "aaaaaaAceeeeiiii", "dnooooo.ouuuuyTy",
    "aaaaaaccccccccdd", "ddeeeeeeeeeegggg",
    "gggghhhhiiiiiiii", "ii..jjkkklllllll",
    "lllnnnnnnn..oooo", "ooOOrrrrrrssssss",
    "ssttttttuuuuuuuu", "uuuuwwyyyzzzzzz."
  };

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       text_end;
  } folded_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_text_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_text_end;

  utf8_latin_fold_stream_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_text_last (in_text_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  // Text bytes waiting to be offered, and folded bytes still to come out
  text_beat_t   text_pending[$];
  folded_beat_t fold_expected[$];

  // Own copy of the fold state: a held lead byte and its five payload bits
  logic       lead_held = 1'b0;
  logic [4:0] lead_low  = 5'd0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int pause_asks     = 0;
  int pause_seen     = 0;
  logic in_taken     = 1'b0;

  int beats_queued = 0;
  int beats_in     = 0;
  int bytes_out    = 0;
  int texts_queued = 0;
  int idle_cycles  = 0;
  int fail_count   = 0;

  // Clock: 4 units high, 4 units low
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fold one accepted text byte and queue the bytes it must produce.
  function automatic void predict_fold(input logic [7:0] b, input logic last);
    logic [7:0]   res [2];
    int           n;
    logic [10:0]  cp;
    logic [7:0]   code;
    logic         paired;
    folded_beat_t beat;
    n = 0;
    paired = 1'b0;
    if (lead_held) begin
      // Pair the held lead with this byte; only a continuation byte in the
      // window can hit the map, anything else releases the lead as it was.
      cp = {lead_low, b[5:0]};
      code = NoBase;
      if (b[7:6] == ContTag && cp >= WindowLow && cp < WindowHigh) begin
        code = AccentBase[(MapDepth - 1 - int'(cp - WindowLow)) * 8 +: 8];
      end
      lead_held = 1'b0;
      if (code != NoBase) begin
        paired = 1'b1;
        case (code)
          LigSs: begin res[0] = "s"; res[1] = "s"; n = 2; end
          LigAe: begin res[0] = "a"; res[1] = "e"; n = 2; end
          LigOe: begin res[0] = "o"; res[1] = "e"; n = 2; end
          LigTh: begin res[0] = "t"; res[1] = "h"; n = 2; end
          default: begin res[0] = code; n = 1; end
        endcase
      end else begin
        res[0] = {LeadTag, lead_low};
        n = 1;
      end
      lead_low = 5'd0;
    end
    if (!paired) begin
      if (!b[7]) begin
        res[n] = (b >= "A" && b <= "Z") ? b + CaseGap : b;
        n++;
      end else if (b[7:5] == LeadTag && !last) begin
        // Hold a fresh lead byte; a lead that ends the text passes as it is
        lead_held = 1'b1;
        lead_low = b[4:0];
      end else begin
        res[n] = b;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      beat.value = res[k];
      beat.run_last = (k == n - 1);
      beat.text_end = (k == n - 1) && last;
      fold_expected.insert(fold_expected.size(), beat);
    end
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    text_beat_t beat;
    beat.value = b;
    beat.last = last;
    text_pending.insert(text_pending.size(), beat);
    beats_queued++;
    if (last) begin
      texts_queued++;
    end
  endtask

  // Wait until every queued byte has gone in and every folded byte has come out.
  task automatic wait_drained();
    while (beats_in != beats_queued || fold_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Queue random texts for one idling phase and let them drain. Most units
  // are well-formed letters or accented pairs; the rest is noise.
  task automatic run_phase(input int send_pct, input int recv_pct, input int nbytes,
                           input bit long_hold, input bit mid_pause);
    int         target;
    int         units;
    int         kind;
    logic       fin;
    logic [10:0] cp;
    logic [7:0] b;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = beats_queued + nbytes;
    while (beats_queued < target) begin
      units = $urandom_range(1, 10);
      for (int u = 0; u < units; u++) begin
        fin = (u == units - 1);
        kind = $urandom_range(0, 99);
        if (fin && $urandom_range(0, 9) == 0) begin
          // Lead byte that ends the text
          queue_byte({LeadTag, 5'($urandom)}, 1'b1);
        end else if (kind < 35) begin
          if ($urandom_range(0, 1) == 1) begin
            b = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "A" : "a");
          end else begin
            b = 8'($urandom_range(0, 127));
          end
          queue_byte(b, fin);
        end else if (kind < 75) begin
          cp = 11'($urandom_range(int'(WindowLow), int'(WindowHigh) - 1));
          queue_byte({LeadTag, cp[10:6]}, 1'b0);
          queue_byte({ContTag, cp[5:0]}, fin);
        end else if (kind < 85) begin
          queue_byte(8'($urandom), fin);
        end else if (kind < 92) begin
          // Lead followed by a byte that cannot continue it
          b = 8'($urandom);
          if (b[7:6] == ContTag) begin
            b[6] = 1'b1;
          end
          queue_byte({LeadTag, 5'($urandom)}, 1'b0);
          queue_byte(b, fin);
        end else begin
          // Any pair shape: overlong, out of window or in the map's gaps
          queue_byte({LeadTag, 5'($urandom)}, 1'b0);
          queue_byte({ContTag, 6'($urandom)}, fin);
        end
      end
    end
    if (long_hold) begin
      hold_asks++;
    end
    if (mid_pause) begin
      while (beats_in < beats_queued - nbytes / 2) begin
        @(negedge clk);
      end
      pause_asks++;
    end
    wait_drained();
  endtask

  // Driver: hold a stalled beat, otherwise offer the next one or idle.
  always @(negedge clk) begin : driver
    text_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled beat as it is
    end else if (pause_seen != pause_asks) begin
      // Pause the sender until every expected byte has come out
      in_valid <= 1'b0;
      if (!in_valid && fold_expected.size() == 0) begin
        pause_seen <= pause_asks;
      end
    end else if (text_pending.size() == 0 ||
                 $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
    end else begin
      beat = text_pending.pop_front();
      in_valid <= 1'b1;
      in_byte <= beat.value;
      in_text_last <= beat.last;
    end
  end

  // Receiver: random stalls, plus a long hold counted here on request
  always @(negedge clk) begin : receiver
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= LongHoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each output beat, and keep
  // an eye on progress.
  always @(posedge clk) begin : monitor
    folded_beat_t want;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_fold(in_byte, in_text_last);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        bytes_out++;
        if (fold_expected.size() == 0) begin
          $error("out_byte %h arrived with nothing expected", out_byte);
          fail_count++;
        end else begin
          want = fold_expected.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %h, got %h", want.value, out_byte);
            fail_count++;
          end
          if (out_run_last !== want.run_last) begin
            $error("out_run_last: expected %b, got %b", want.run_last, out_run_last);
            fail_count++;
          end
          if (out_text_end !== want.text_end) begin
            $error("out_text_end: expected %b, got %b", want.text_end, out_text_end);
            fail_count++;
          end
        end
      end
      // Drop the run if nothing moves on either side for too long
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    // Hold reset at the start, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text: case edges, extreme bytes, stray and long-sequence
    // bytes, the ss and oe ligatures, a map gap, a pair below the window, an
    // overlong form, a broken pair, a lead that breaks a pair, the last
    // entry gap, and a lead that ends the text.
    queue_byte("A", 1'b0);
    queue_byte("Z", 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h9F, 1'b0);
    queue_byte(8'hC5, 1'b0); queue_byte(8'h92, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h97, 1'b0);
    queue_byte(8'hC2, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hC1, 1'b0); queue_byte(8'h81, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h41, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'hC4, 1'b0); queue_byte(8'h85, 1'b0);
    queue_byte(8'hC5, 1'b0); queue_byte(8'hBF, 1'b0);
    queue_byte(8'hC3, 1'b1);
    wait_drained();

    // Random phases: free running with a long receiver hold, idle sender,
    // stalling receiver, then both with a pause of the sender midway
    run_phase(0, 0, 350, 1'b1, 1'b0);
    run_phase(61, 0, 350, 1'b0, 1'b0);
    run_phase(0, 61, 350, 1'b0, 1'b0);
    run_phase(14, 14, 350, 1'b0, 1'b1);

    repeat (SettleCycles) @(posedge clk);
    if (fold_expected.size() != 0) begin
      $error("%0d folded bytes never arrived", fold_expected.size());
      fail_count++;
    end

    $display("Folded %0d input bytes in %0d texts into %0d output bytes,",
             beats_in, texts_queued, bytes_out);
    $display("across four idling phases with a long output hold and a sender pause.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
